// ----- rtl/core/bbbox_pkg.sv -----
`default_nettype none

package bbbox_pkg;

  // Saturating column and row sums
  localparam int unsigned SumW  = 20;
  // Positions reported on the result channel
  localparam int unsigned PosW  = 12;
  localparam int unsigned PixW  = 8;
  localparam int unsigned CfgW  = 13;

  typedef logic [SumW-1:0] sum_t;
  typedef logic [PixW-1:0] pix_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [CfgW-1:0] cfg_t;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Packed from the top: found lands in bit 0
  typedef struct packed {
    pos_t bottom_row;
    pos_t top_row;
    pos_t right_column;
    pos_t left_column;
    logic found;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

  function automatic sum_t sat_add(sum_t a, pix_t b);
    logic [SumW:0] s;
    s = {1'b0, a} + {{(SumW + 1 - PixW){1'b0}}, b};
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/black_border_bounding_box.sv -----
// Black-border bounding box. Pixels of one gray frame arrive in raster order, one
// 8-bit pixel per input beat. A column is non-black when the sum of its pixels
// reaches the frame height, a row when its sum reaches the frame width (a mean of
// at least one). After the last pixel of a frame the block emits one result beat:
// found, then the inclusive left and right column and top and bottom row of the
// non-black area (all zero when found is 0). Column sums live in a single-port-pair
// RAM of MAX_WIDTH entries; each pixel does one read-modify-write of its column, so
// the block takes one pixel every cycle. The read is issued as the pixel is taken,
// the update and write-back happen in stage 1, and a write to the column being
// read in that same cycle is forwarded. The last pixel of a frame loads the result
// register. Input stalls only when the next frame ends while the previous
// result still waits on the output. Frame width and height (register 0 and 1)
// must be written between frames; 0 acts as 1, values above MAX_WIDTH/MAX_HEIGHT
// act as those limits. No clearing pass runs after reset: the first row of every
// frame loads the column sums instead of adding to them.
`default_nettype none

module black_border_bounding_box #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config write port
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_index_i,
  input  wire bbbox_pkg::cfg_t                cfg_data_i,
  // pixel stream; tdata: pixel[7:0]
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [7:0]                     s_axis_tdata_i,
  // result stream; tdata: found[0], left_column[12:1], right_column[24:13],
  // top_row[36:25], bottom_row[48:37], zero fill above
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [bbbox_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  import bbbox_pkg::*;

  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  typedef logic [XW-1:0] xpos_t;
  typedef logic [YW-1:0] ypos_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgW'(640);
      frame_height_q <= CfgW'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp sizes into 1..MAX
  logic [31:0] w_raw, h_raw, w_eff, h_eff;

  always_comb begin
    w_raw = 32'(frame_width_q);
    h_raw = 32'(frame_height_q);
    if (w_raw == 32'd0)                   w_eff = 32'd1;
    else if (w_raw > 32'(MAX_WIDTH))      w_eff = 32'(MAX_WIDTH);
    else                                  w_eff = w_raw;
    if (h_raw == 32'd0)                   h_eff = 32'd1;
    else if (h_raw > 32'(MAX_HEIGHT))     h_eff = 32'(MAX_HEIGHT);
    else                                  h_eff = h_raw;
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position tracking, row sums, column read
  // ---------------------------------------------------------------------------
  xpos_t x_q, x_d;
  ypos_t y_q, y_d;
  sum_t  row_sum_q, row_sum_d;
  logic  row_seen_q, row_seen_d;
  ypos_t top_q, top_d, bottom_q, bottom_d;

  logic  in_accept, s1_fire;
  logic  last_col, last_row;
  sum_t  rs_add;
  logic  row_hit, row_seen_n;
  ypos_t top_n, bottom_n;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign last_col  = 32'(x_q) >= (w_eff - 32'd1);
  assign last_row  = 32'(y_q) >= (h_eff - 32'd1);

  always_comb begin
    rs_add     = sat_add(row_sum_q, s_axis_tdata_i);
    row_hit    = last_col && (32'(rs_add) >= w_eff);
    row_seen_n = row_seen_q || row_hit;
    top_n      = (row_hit && !row_seen_q) ? y_q : top_q;
    bottom_n   = row_hit ? y_q : bottom_q;
  end

  always_comb begin
    x_d        = x_q;
    y_d        = y_q;
    row_sum_d  = row_sum_q;
    row_seen_d = row_seen_q;
    top_d      = top_q;
    bottom_d   = bottom_q;
    if (in_accept) begin
      if (!last_col) begin
        x_d       = x_q + XW'(1);
        row_sum_d = rs_add;
      end else begin
        x_d       = '0;
        row_sum_d = '0;
        if (!last_row) begin
          y_d        = y_q + YW'(1);
          row_seen_d = row_seen_n;
          top_d      = top_n;
          bottom_d   = bottom_n;
        end else begin
          // frame done: row bounds travel with the last pixel
          y_d        = '0;
          row_seen_d = 1'b0;
          top_d      = '0;
          bottom_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q        <= '0;
      y_q        <= '0;
      row_sum_q  <= '0;
      row_seen_q <= 1'b0;
      top_q      <= '0;
      bottom_q   <= '0;
    end else begin
      x_q        <= x_d;
      y_q        <= y_d;
      row_sum_q  <= row_sum_d;
      row_seen_q <= row_seen_d;
      top_q      <= top_d;
      bottom_q   <= bottom_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 pipeline register
  // ---------------------------------------------------------------------------
  logic  s1_valid_q;
  pix_t  s1_pix_q;
  xpos_t s1_x_q;
  logic  s1_first_q, s1_last_row_q, s1_end_q;
  logic  s1_row_seen_q;
  ypos_t s1_top_q, s1_bottom_q;

  logic  out_valid_q;

  // Only a frame end can block, and only while the previous result waits
  assign s1_fire         = s1_valid_q && (!s1_end_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q      <= s_axis_tdata_i;
      s1_x_q        <= x_q;
      s1_first_q    <= (y_q == '0);
      s1_last_row_q <= last_row;
      s1_end_q      <= last_col && last_row;
      s1_row_seen_q <= row_seen_n;
      s1_top_q      <= top_n;
      s1_bottom_q   <= bottom_n;
    end
  end

  // ---------------------------------------------------------------------------
  // Column sum memory with write-to-read forwarding
  // ---------------------------------------------------------------------------
  sum_t ram_rdata, col_base, col_sum;
  logic fwd_valid_q;
  sum_t fwd_data_q;

  bbbox_ram #(
    .Width (SumW),
    .Depth (MAX_WIDTH)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_x_q),
    .wdata_i (col_sum),
    .re_i    (in_accept),
    .raddr_i (x_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (in_accept) begin
      fwd_valid_q <= s1_fire && (s1_x_q == x_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_data_q <= col_sum;
    end
  end

  always_comb begin
    col_base = fwd_valid_q ? fwd_data_q : ram_rdata;
    col_sum  = s1_first_q ? {{(SumW - PixW){1'b0}}, s1_pix_q} : sat_add(col_base, s1_pix_q);
  end

  // ---------------------------------------------------------------------------
  // Column bounds, checked on the last row only
  // ---------------------------------------------------------------------------
  logic  col_seen_q, col_seen_n;
  xpos_t left_q, left_n, right_q, right_n;
  logic  col_hit;

  always_comb begin
    col_hit    = s1_last_row_q && (32'(col_sum) >= h_eff);
    col_seen_n = col_seen_q || col_hit;
    left_n     = (col_hit && !col_seen_q) ? s1_x_q : left_q;
    right_n    = col_hit ? s1_x_q : right_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_seen_q <= 1'b0;
      left_q     <= '0;
      right_q    <= '0;
    end else if (s1_fire) begin
      if (s1_end_q) begin
        col_seen_q <= 1'b0;
        left_q     <= '0;
        right_q    <= '0;
      end else begin
        col_seen_q <= col_seen_n;
        left_q     <= left_n;
        right_q    <= right_n;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  result_t result_q, result_d;
  logic    found;
  logic [31:0] left32, right32, top32, bottom32;

  always_comb begin
    found    = col_seen_n && s1_row_seen_q;
    left32   = 32'(left_n);
    right32  = 32'(right_n);
    top32    = 32'(s1_top_q);
    bottom32 = 32'(s1_bottom_q);
    result_d.found        = found;
    result_d.left_column  = found ? left32[PosW-1:0]   : '0;
    result_d.right_column = found ? right32[PosW-1:0]  : '0;
    result_d.top_row      = found ? top32[PosW-1:0]    : '0;
    result_d.bottom_row   = found ? bottom32[PosW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_end_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_end_q) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - ResultW){1'b0}}, result_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_end_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_end_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while a frame end is blocked");

  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(fwd_valid_q)) |-> $past(s1_fire && in_accept))
    else $error("forwarding without a same-cycle write");

  a_end_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_end_q) |=> m_axis_tvalid_o)
    else $error("frame end did not raise a result");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !result_q.found) |->
      (result_q.left_column == '0 && result_q.right_column == '0 &&
       result_q.top_row == '0 && result_q.bottom_row == '0))
    else $error("black frame with nonzero bounds");

endmodule

`default_nettype wire

// ----- rtl/core/bbbox_ram.sv -----
`default_nettype none

module bbbox_ram #(
  parameter int unsigned Width = 20,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_black_border_bounding_box.sv -----
`timescale 1ns / 100ps

module tb_black_border_bounding_box;
  import bbbox_pkg::*;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned SumMax     = (1 << SumW) - 1;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandomPix  = 560;

  // Frame content styles
  localparam int unsigned StyleNoise  = 0;
  localparam int unsigned StyleRect   = 1;
  localparam int unsigned StyleBlack  = 2;
  localparam int unsigned StyleSparse = 3;
  localparam int unsigned StyleDim    = 4;
  localparam int unsigned StyleCount  = 5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic     cfg_we = 1'b0;
  cfg_reg_e cfg_index = REG_FRAME_WIDTH;
  cfg_t     cfg_data = '0;

  logic     pix_valid = 1'b0;
  wire      pix_ready;
  pix_t     pix_data = '0;

  wire                res_valid;
  logic               res_ready = 1'b0;
  wire [OutDataW-1:0] res_data;

  always #5 clk = ~clk;

  black_border_bounding_box #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(pix_valid),
    .s_axis_tready_o(pix_ready),
    .s_axis_tdata_i (pix_data),   // pixel[7:0]
    .m_axis_tvalid_o(res_valid),
    .m_axis_tready_i(res_ready),
    // found[0], left_column[12:1], right_column[24:13], top_row[36:25],
    // bottom_row[48:37], zero fill above
    .m_axis_tdata_o (res_data)
  );

  // ---------------------------------------------------------------------------
  // Bounding box tracker: own copy of the size registers and frame state
  // ---------------------------------------------------------------------------
  cfg_t        width_reg = cfg_t'(640);
  cfg_t        height_reg = cfg_t'(480);
  sum_t        col_acc [MaxWidth];
  sum_t        row_acc = '0;
  int unsigned x_pos = 0;
  int unsigned y_pos = 0;
  int unsigned lo_col = 0;
  int unsigned hi_col = 0;
  int unsigned lo_row = 0;
  int unsigned hi_row = 0;
  bit          col_hit = 1'b0;
  bit          row_hit = 1'b0;

  result_t     bbox_pending [$];
  pix_t        pixel_backlog [$];

  int unsigned pixels_queued = 0;
  int unsigned pixels_taken = 0;
  int unsigned frames_checked = 0;
  int unsigned boxes_found = 0;
  int unsigned errors = 0;

  // Registers are sampled at the edge, so the new size applies from the next beat
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) width_reg <= cfg_data;
      else height_reg <= cfg_data;
    end
  end

  // 0 acts as 1, anything past the array size acts as the array size
  function automatic int unsigned eff_size(cfg_t v, int unsigned lim);
    if (v == '0) return 1;
    if (32'(v) > lim) return lim;
    return 32'(v);
  endfunction

  function automatic sum_t acc_sat(sum_t a, pix_t b);
    int unsigned s;
    s = 32'(a) + 32'(b);
    return (s > SumMax) ? sum_t'(SumMax) : sum_t'(s);
  endfunction

  task automatic track_pixel(input pix_t p);
    int unsigned w;
    int unsigned h;
    bit          last_col;
    bit          last_row;
    sum_t        cs;
    result_t     r;
    w = eff_size(width_reg, MaxWidth);
    h = eff_size(height_reg, MaxHeight);
    last_col = (x_pos >= w - 1);
    last_row = (y_pos >= h - 1);
    if (x_pos < MaxWidth) begin
      // first row loads the column, so nothing carries over between frames
      cs = (y_pos == 0) ? sum_t'(p) : acc_sat(col_acc[x_pos[11:0]], p);
      col_acc[x_pos[11:0]] = cs;
      if (last_row && 32'(cs) >= h) begin
        if (!col_hit) lo_col = x_pos;
        hi_col = x_pos;
        col_hit = 1'b1;
      end
    end
    row_acc = acc_sat(row_acc, p);
    if (!last_col) begin
      x_pos++;
    end else begin
      if (32'(row_acc) >= w) begin
        if (!row_hit) lo_row = y_pos;
        hi_row = y_pos;
        row_hit = 1'b1;
      end
      row_acc = '0;
      x_pos = 0;
      if (!last_row) begin
        y_pos++;
      end else begin
        r = '0;
        r.found = col_hit && row_hit;
        if (r.found) begin
          r.left_column  = pos_t'(lo_col);
          r.right_column = pos_t'(hi_col);
          r.top_row      = pos_t'(lo_row);
          r.bottom_row   = pos_t'(hi_row);
        end
        bbox_pending.push_back(r);
        y_pos = 0;
        lo_col = 0;
        hi_col = 0;
        lo_row = 0;
        hi_row = 0;
        col_hit = 1'b0;
        row_hit = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && pix_valid && pix_ready) begin
      track_pixel(pix_data);
      pixels_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel driver: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pix_valid <= 1'b0;
      pix_data <= '0;
    end else if (!pix_valid || pix_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        pix_valid <= 1'b0;
      end else if (pixel_backlog.size() > 0) begin
        pix_valid <= 1'b1;
        pix_data <= pixel_backlog.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: rotating stall pattern, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned pattern_age = 0;
  int unsigned holdoff_req = 0;
  int unsigned holdoff_seen = 0;
  int unsigned holdoff_left = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      if (holdoff_seen != holdoff_req) begin
        holdoff_seen = holdoff_req;
        holdoff_left = HoldCycles;
      end
      if (pattern_age == 0) begin
        pattern_age = 97;
        ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom());
      end else begin
        pattern_age--;
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ready_pattern[0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  result_t got;
  result_t want;

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && res_valid && res_ready) begin
      got = result_t'(res_data[ResultW-1:0]);
      if (res_data[OutDataW-1:ResultW] != '0) begin
        errors++;
        $display("%0t: fill bits mismatch, expected 0, actual %h", $time,
                 res_data[OutDataW-1:ResultW]);
      end
      if (bbox_pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, res_data);
      end else begin
        want = bbox_pending.pop_front();
        check_field("found", 32'(want.found), 32'(got.found));
        check_field("left_column", 32'(want.left_column), 32'(got.left_column));
        check_field("right_column", 32'(want.right_column), 32'(got.right_column));
        check_field("top_row", 32'(want.top_row), 32'(got.top_row));
        check_field("bottom_row", 32'(want.bottom_row), 32'(got.bottom_row));
        frames_checked++;
        if (want.found) boxes_found++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any beat or register write ends the run
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((pix_valid && pix_ready) || (res_valid && res_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("tb_black_border_bounding_box: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic program_size(input cfg_t w, input cfg_t h);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued pixel is taken and every frame result has come back
  task automatic drain();
    while (pixels_taken != pixels_queued || bbox_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_pixel(input pix_t p);
    pixel_backlog.push_back(p);
    pixels_queued++;
  endtask

  // Queue one frame for the current register values
  task automatic queue_frame(input cfg_t w_reg, input cfg_t h_reg, input int unsigned style);
    int unsigned w;
    int unsigned h;
    int unsigned x0;
    int unsigned x1;
    int unsigned y0;
    int unsigned y1;
    bit          lit;
    pix_t        p;
    w = eff_size(w_reg, MaxWidth);
    h = eff_size(h_reg, MaxHeight);
    x0 = $urandom_range(0, w - 1);
    x1 = $urandom_range(x0, w - 1);
    y0 = $urandom_range(0, h - 1);
    y1 = $urandom_range(y0, h - 1);
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        lit = (x >= x0) && (x <= x1) && (y >= y0) && (y <= y1);
        case (style)
          StyleNoise: begin
            p = pix_t'($urandom_range(0, 255));
          end
          StyleRect: begin
            if (lit) p = ($urandom_range(0, 3) == 0) ? pix_t'($urandom_range(0, 3))
                                                    : pix_t'($urandom_range(1, 255));
            else p = ($urandom_range(0, 7) == 0) ? pix_t'($urandom_range(0, 2)) : '0;
          end
          StyleBlack: begin
            p = '0;
          end
          StyleSparse: begin
            p = ($urandom_range(0, 15) == 0) ? pix_t'($urandom_range(0, 255)) : '0;
          end
          default: begin
            // hover around a mean of one
            p = pix_t'($urandom_range(0, 2));
          end
        endcase
        push_pixel(p);
      end
    end
  endtask

  int unsigned random_pixels;
  int unsigned start_count;
  cfg_t        w_raw;
  cfg_t        h_raw;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero sizes act as a single pixel: black, full white, exactly at threshold
    program_size('0, '0);
    push_pixel(8'd0);
    push_pixel(8'd255);
    push_pixel(8'd1);
    drain();

    // 2x2: mean exactly one everywhere, then a single lit corner
    program_size(cfg_t'(2), cfg_t'(2));
    repeat (4) push_pixel(8'd1);
    push_pixel(8'd0);
    push_pixel(8'd0);
    push_pixel(8'd0);
    push_pixel(8'd2);
    drain();

    // 3x2: a column crosses the threshold but no row does, so nothing found
    program_size(cfg_t'(3), cfg_t'(2));
    push_pixel(8'd0);
    push_pixel(8'd2);
    repeat (4) push_pixel(8'd0);
    drain();

    // Hold the receiver off on one-pixel frames so results back up and the
    // pixel side stalls
    program_size(cfg_t'(1), cfg_t'(1));
    holdoff_req++;
    repeat (60) push_pixel(pix_t'($urandom_range(0, 3)));
    drain();

    // Random sizes, several frames per setting, mostly small
    random_pixels = 0;
    while (random_pixels < RandomPix) begin
      w_raw = ($urandom_range(0, 9) == 0) ? cfg_t'(0) : cfg_t'($urandom_range(1, 20));
      h_raw = ($urandom_range(0, 9) == 0) ? cfg_t'(0) : cfg_t'($urandom_range(1, 12));
      program_size(w_raw, h_raw);
      start_count = pixels_queued;
      repeat ($urandom_range(1, 4)) begin
        queue_frame(w_raw, h_raw, $urandom_range(0, StyleCount - 1));
      end
      random_pixels += pixels_queued - start_count;
      drain();
    end

    // Long single rows and columns, and a zero height on a wide row
    program_size(cfg_t'(64), cfg_t'(1));
    queue_frame(cfg_t'(64), cfg_t'(1), StyleRect);
    drain();
    program_size(cfg_t'(1), cfg_t'(48));
    queue_frame(cfg_t'(1), cfg_t'(48), StyleRect);
    drain();
    program_size(cfg_t'(32), cfg_t'(0));
    queue_frame(cfg_t'(32), cfg_t'(0), StyleSparse);
    drain();

    repeat (20) @(posedge clk);
    $display("covered %0d pixels in %0d frames (%0d with a box), sizes from 1x1 to 64x1",
             pixels_taken, frames_checked, boxes_found);
    $display("and 1x48, with zero-size registers and a stalled result side");
    if (errors == 0) begin
      $display("tb_black_border_bounding_box: done, clean");
    end else begin
      $display("tb_black_border_bounding_box: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bbbox_pkg.sv
rtl/core/bbbox_ram.sv
rtl/core/black_border_bounding_box.sv
tb/tb_black_border_bounding_box.sv
